// ===== src/emm_pkg.sv =====
// ----------------------------------------------------------------------------
// emm_pkg
// Shared types and constants of the exact-match key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package emm_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_ANY    = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_EXIST  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_MODE = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Lookup result of the table for the key in the input register.
  typedef struct packed {
    logic hit;
    logic full;
  } table_flags_t;

  // What the control decides to do with the current word.
  typedef struct packed {
    logic update;  // overwrite the value of the matching entry
    logic insert;  // write key and value into the lowest free entry
    logic remove;  // clear the valid bit of the matching entry
    logic read;    // return the stored value
  } table_cmd_t;

endpackage

`default_nettype wire

// ===== src/emm_table.sv =====
// ----------------------------------------------------------------------------
// emm_table
// Entry storage with parallel key compare, free-entry search and write port.
// ----------------------------------------------------------------------------
`default_nettype none

module emm_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [emm_pkg::KEY_BITS-1:0]      key,
  input  wire logic [emm_pkg::VALUE_BITS-1:0]    wdata,
  input  wire logic                              enable,
  input  wire emm_pkg::table_cmd_t               cmd,
  output emm_pkg::table_flags_t                  flags,
  output logic [emm_pkg::VALUE_BITS-1:0]         rdata
);

  logic [emm_pkg::ENTRIES-1:0]    valid;
  logic [emm_pkg::KEY_BITS-1:0]   keys   [emm_pkg::ENTRIES];
  logic [emm_pkg::VALUE_BITS-1:0] values [emm_pkg::ENTRIES];

  logic [emm_pkg::ENTRIES-1:0] match;
  logic [emm_pkg::ENTRIES-1:0] free;
  logic [emm_pkg::ENTRIES-1:0] free_low;

  always_comb begin
    for (int i = 0; i < emm_pkg::ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key);
    end
  end

  // Isolate the lowest set bit of the free vector.
  assign free     = ~valid;
  assign free_low = free & (~free + emm_pkg::ENTRIES'(1));

  assign flags.hit  = |match;
  assign flags.full = ~|free;

  // At most one entry matches, so an AND-OR gives its value.
  always_comb begin
    rdata = '0;
    for (int i = 0; i < emm_pkg::ENTRIES; i++) begin
      rdata = rdata | ({emm_pkg::VALUE_BITS{match[i]}} & values[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (enable) begin
      for (int i = 0; i < emm_pkg::ENTRIES; i++) begin
        if (cmd.insert && free_low[i]) begin
          valid[i] <= 1'b1;
        end else if (cmd.remove && match[i]) begin
          valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      for (int i = 0; i < emm_pkg::ENTRIES; i++) begin
        if (cmd.insert && free_low[i]) begin
          keys[i]   <= key;
          values[i] <= wdata;
        end else if (cmd.update && match[i]) begin
          values[i] <= wdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/emm_decide.sv =====
// ----------------------------------------------------------------------------
// emm_decide
// Request decode: checks operation and update mode against the table flags.
// ----------------------------------------------------------------------------
`default_nettype none

module emm_decide (
  input  wire logic [1:0]            func,
  input  wire logic [1:0]            update_mode,
  input  wire emm_pkg::table_flags_t flags,
  output emm_pkg::table_cmd_t        cmd,
  output emm_pkg::status_t           status
);

  always_comb begin
    cmd    = '0;
    status = emm_pkg::ST_OK;
    unique case (emm_pkg::func_t'(func))
      emm_pkg::FUNC_LOOKUP: begin
        cmd.read = flags.hit;
      end
      emm_pkg::FUNC_UPDATE: begin
        unique case (emm_pkg::mode_t'(update_mode))
          emm_pkg::MODE_ANY, emm_pkg::MODE_CREATE, emm_pkg::MODE_EXIST: begin
            if (flags.hit && update_mode == emm_pkg::MODE_CREATE) begin
              status = emm_pkg::ST_EXISTS;
            end else if (!flags.hit && update_mode == emm_pkg::MODE_EXIST) begin
              status = emm_pkg::ST_NO_ENTRY;
            end else if (flags.hit) begin
              cmd.update = 1'b1;
            end else if (flags.full) begin
              status = emm_pkg::ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
          default: begin
            status = emm_pkg::ST_BAD_MODE;
          end
        endcase
      end
      emm_pkg::FUNC_DELETE: begin
        cmd.remove = flags.hit;
      end
      default: begin
        status = emm_pkg::ST_BAD_MODE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/exact_match_map_with_update_flags.sv =====
// ----------------------------------------------------------------------------
// exact_match_map_with_update_flags
// Exact-match key/value table with lookup, conditional update and delete.
// ----------------------------------------------------------------------------
// The table holds 64 entries in flip-flops and compares every entry against
// the key at once. A word is captured in an input register; once the output
// register can advance, its key is matched, its update or delete is applied
// to the table and its result is loaded into the output register. One word is
// accepted every cycle while results are taken; a stalled result side holds
// the flow. The combinational parallel compare and free-entry search bound
// that rate. While a result waits, one more word is still taken if the input
// register is empty. Inserts go to the lowest-numbered free entry.
`default_nettype none

module exact_match_map_with_update_flags (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     func,
  input  wire logic [emm_pkg::KEY_BITS-1:0]   lookup_key,
  input  wire logic [emm_pkg::VALUE_BITS-1:0] write_value,
  input  wire logic [1:0]                     update_mode,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                hit,
  output logic [emm_pkg::VALUE_BITS-1:0]      read_value,
  output logic [2:0]                          status
);

  logic                            req_valid;
  logic [1:0]                      req_func;
  logic [emm_pkg::KEY_BITS-1:0]    req_key;
  logic [emm_pkg::VALUE_BITS-1:0]  req_value;
  logic [1:0]                      req_mode;

  logic                            advance;
  logic                            process;
  emm_pkg::table_flags_t           flags;
  emm_pkg::table_cmd_t             cmd;
  emm_pkg::status_t                req_status;
  logic [emm_pkg::VALUE_BITS-1:0]  rdata;

  assign advance  = !out_valid || out_ready;
  assign process  = req_valid && advance;
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_func  <= func;
      req_key   <= lookup_key;
      req_value <= write_value;
      req_mode  <= update_mode;
    end
  end

  emm_table u_table (
    .clk    (clk),
    .rst    (rst),
    .key    (req_key),
    .wdata  (req_value),
    .enable (process),
    .cmd    (cmd),
    .flags  (flags),
    .rdata  (rdata)
  );

  emm_decide u_decide (
    .func        (req_func),
    .update_mode (req_mode),
    .flags       (flags),
    .cmd         (cmd),
    .status      (req_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      hit        <= flags.hit;
      read_value <= cmd.read ? rdata : '0;
      status     <= req_status;
    end
  end

`ifndef SYNTHESIS
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.update, cmd.insert, cmd.remove}))
    else $error("more than one table action for one word");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == '0)
    else $error("read value nonzero on a miss");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == emm_pkg::ST_FULL |-> !hit)
    else $error("table full reported for a present key");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !req_valid)
    else $error("valid set right after reset");
`endif

endmodule

`default_nettype wire

// ===== bench/exact_match_map_with_update_flags_tb.sv =====
// ----------------------------------------------------------------------------
// exact_match_map_with_update_flags_tb
// Self-checking bench for the exact-match key/value table.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel, with random gaps on the request
// side and random stalls on the result side. The bench keeps its own copy of
// the table and predicts every reply when a word is accepted. Replies are
// compared field by field, in order, as they leave the block. The tests cover
// directed corner cases, filling the table to capacity, a long random mix on
// a small key pool, and a final burst with no idling.
module exact_match_map_with_update_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package enums do not name.
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam int POOL_SIZE      = 80;
  localparam int WATCHDOG_LIMIT = 500;

  typedef struct packed {
    logic                           hit;
    logic [emm_pkg::VALUE_BITS-1:0] read_value;
    emm_pkg::status_t               status;
  } table_reply_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     func = 2'd0;
  logic [emm_pkg::KEY_BITS-1:0]   lookup_key = '0;
  logic [emm_pkg::VALUE_BITS-1:0] write_value = '0;
  logic [1:0]                     update_mode = 2'd0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           hit;
  logic [emm_pkg::VALUE_BITS-1:0] read_value;
  logic [2:0]                     status;

  // Copy of the table as the block should hold it.
  logic                           slot_used [emm_pkg::ENTRIES];
  logic [emm_pkg::KEY_BITS-1:0]   slot_key [emm_pkg::ENTRIES];
  logic [emm_pkg::VALUE_BITS-1:0] slot_value [emm_pkg::ENTRIES];

  table_reply_t                   expected_replies[$];
  logic [emm_pkg::KEY_BITS-1:0]   key_pool [POOL_SIZE];
  int                             mismatch_count = 0;
  int                             idle_cycles = 0;
  int                             gap_pct = 0;
  int                             stall_pct = 0;

  exact_match_map_with_update_flags dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .update_mode (update_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the bench's table and returns the reply it owes.
  function automatic table_reply_t table_access(
      logic [1:0] op, logic [emm_pkg::KEY_BITS-1:0] key,
      logic [emm_pkg::VALUE_BITS-1:0] value, logic [1:0] mode);
    table_reply_t reply;
    int           match_idx;
    int           free_idx;
    match_idx = -1;
    free_idx  = -1;
    for (int i = emm_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) match_idx = i;
      if (!slot_used[i]) free_idx = i;
    end
    reply.hit        = (match_idx >= 0);
    reply.read_value = '0;
    reply.status     = emm_pkg::ST_OK;
    case (op)
      emm_pkg::FUNC_LOOKUP: begin
        if (match_idx >= 0) reply.read_value = slot_value[match_idx];
      end
      emm_pkg::FUNC_UPDATE: begin
        if (mode == MODE_UNKNOWN) reply.status = emm_pkg::ST_BAD_MODE;
        else if (match_idx >= 0 && mode == emm_pkg::MODE_CREATE)
          reply.status = emm_pkg::ST_EXISTS;
        else if (match_idx < 0 && mode == emm_pkg::MODE_EXIST)
          reply.status = emm_pkg::ST_NO_ENTRY;
        else if (match_idx >= 0) slot_value[match_idx] = value;
        else if (free_idx < 0) reply.status = emm_pkg::ST_FULL;
        else begin
          slot_used[free_idx]  = 1'b1;
          slot_key[free_idx]   = key;
          slot_value[free_idx] = value;
        end
      end
      emm_pkg::FUNC_DELETE: begin
        if (match_idx >= 0) slot_used[match_idx] = 1'b0;
      end
      default: reply.status = emm_pkg::ST_BAD_MODE;
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sends one word; returns at the edge where it was accepted.
  task automatic send_word(input logic [1:0] op, input logic [emm_pkg::KEY_BITS-1:0] key,
                           input logic [emm_pkg::VALUE_BITS-1:0] value,
                           input logic [1:0] mode);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    lookup_key  <= key;
    write_value <= value;
    update_mode <= mode;
    do @(posedge clk); while (!in_ready);
    expected_replies.push_back(table_access(op, key, value, mode));
  endtask

  // Holds the request side off until every reply is back.
  task automatic wait_for_replies;
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [emm_pkg::VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic test_directed_cases;
    send_word(emm_pkg::FUNC_LOOKUP, '0, '1, MODE_UNKNOWN);
    send_word(emm_pkg::FUNC_UPDATE, '0, '1, emm_pkg::MODE_EXIST);
    send_word(emm_pkg::FUNC_UPDATE, '0, '1, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, '0, '0, emm_pkg::MODE_CREATE);
    send_word(emm_pkg::FUNC_UPDATE, '1, '0, emm_pkg::MODE_CREATE);
    send_word(emm_pkg::FUNC_UPDATE, '1, 32'h5a5a_5a5a, emm_pkg::MODE_CREATE);
    send_word(emm_pkg::FUNC_LOOKUP, '1, 32'h1234_5678, emm_pkg::MODE_EXIST);
    send_word(emm_pkg::FUNC_UPDATE, '0, 32'h1234_5678, emm_pkg::MODE_EXIST);
    send_word(emm_pkg::FUNC_UPDATE, '0, 32'ha5a5_a5a5, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, '0, '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_UPDATE, '0, 32'd1, MODE_UNKNOWN);
    send_word(emm_pkg::FUNC_UPDATE, 32'd77, 32'd1, MODE_UNKNOWN);
    send_word(FUNC_UNUSED, '0, '1, emm_pkg::MODE_ANY);
    send_word(FUNC_UNUSED, 32'd77, '0, MODE_UNKNOWN);
    send_word(emm_pkg::FUNC_DELETE, '0, '1, emm_pkg::MODE_CREATE);
    send_word(emm_pkg::FUNC_DELETE, '0, '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, '0, '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, '1, '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_DELETE, '1, '0, emm_pkg::MODE_EXIST);
  endtask

  task automatic test_table_full;
    logic [emm_pkg::KEY_BITS-1:0] fill_keys [emm_pkg::ENTRIES];
    logic [emm_pkg::KEY_BITS-1:0] spare_key;
    for (int i = 0; i < emm_pkg::ENTRIES; i++) begin
      // The low byte keeps the keys distinct.
      fill_keys[i] = {24'($urandom_range(0, 32'hff_ffff)), 8'(i)};
      send_word(emm_pkg::FUNC_UPDATE, fill_keys[i], pick_value(), emm_pkg::MODE_CREATE);
    end
    spare_key = {24'($urandom_range(0, 32'hff_ffff)), 8'hff};
    send_word(emm_pkg::FUNC_UPDATE, spare_key, pick_value(), emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_UPDATE, spare_key, pick_value(), emm_pkg::MODE_CREATE);
    send_word(emm_pkg::FUNC_UPDATE, spare_key, pick_value(), MODE_UNKNOWN);
    send_word(emm_pkg::FUNC_UPDATE, fill_keys[5], pick_value(), emm_pkg::MODE_EXIST);
    send_word(emm_pkg::FUNC_UPDATE, fill_keys[emm_pkg::ENTRIES-1], pick_value(),
              emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, fill_keys[5], '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_DELETE, fill_keys[10], '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_UPDATE, spare_key, pick_value(), emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_UPDATE, spare_key ^ 32'h100, pick_value(), emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_LOOKUP, spare_key, '0, emm_pkg::MODE_ANY);
    // Empty the table again so the random mix starts with room.
    for (int i = 0; i < emm_pkg::ENTRIES; i++)
      send_word(emm_pkg::FUNC_DELETE, fill_keys[i], '0, emm_pkg::MODE_ANY);
    send_word(emm_pkg::FUNC_DELETE, spare_key, '0, emm_pkg::MODE_ANY);
  endtask

  task automatic random_word;
    logic [1:0]                   op;
    logic [1:0]                   mode;
    logic [emm_pkg::KEY_BITS-1:0] key;
    int                           r;
    r = $urandom_range(0, 99);
    if (r < 35) op = emm_pkg::FUNC_LOOKUP;
    else if (r < 75) op = emm_pkg::FUNC_UPDATE;
    else if (r < 95) op = emm_pkg::FUNC_DELETE;
    else op = FUNC_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 40) mode = emm_pkg::MODE_ANY;
    else if (r < 65) mode = emm_pkg::MODE_CREATE;
    else if (r < 90) mode = emm_pkg::MODE_EXIST;
    else mode = MODE_UNKNOWN;
    // A small key pool keeps hits frequent; a few keys are drawn fresh.
    if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = $urandom;
    send_word(op, key, pick_value(), mode);
  endtask

  task automatic test_random_mix;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int blk = 0; blk < 14; blk++) begin
      gap_pct   = (blk == 3) ? 0 : 12 * $urandom_range(0, 2);
      stall_pct = (blk == 3) ? 0 : 12 * $urandom_range(0, 2);
      for (int i = 0; i < 100; i++) random_word();
      if (blk == 6) wait_for_replies();
    end
  endtask

  task automatic test_back_to_back;
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < 200; i++) random_word();
  endtask

  initial begin
    for (int i = 0; i < emm_pkg::ENTRIES; i++) slot_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 20;
    stall_pct = 20;
    test_directed_cases();
    test_table_full();
    wait_for_replies();
    test_random_mix();
    wait_for_replies();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Result side: random stall bursts, otherwise always ready.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending");
      end else begin
        want = expected_replies.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
        if (read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h", read_value,
                                    want.read_value));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  end

  // Ends a hung run: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
